/* rtl/upc_pkg.sv */
// Shared types, character codes and helpers for the URL percent codec.
`default_nettype none

package upc_pkg;

	// Character codes
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_UA      = 8'h41;
	localparam logic [7:0] CH_UF      = 8'h46;
	localparam logic [7:0] CH_UZ      = 8'h5A;
	localparam logic [7:0] CH_LA      = 8'h61;
	localparam logic [7:0] CH_LF      = 8'h66;
	localparam logic [7:0] CH_LZ      = 8'h7A;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_USCORE  = 8'h5F;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_TILDE   = 8'h7E;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;

	// Offsets from a nibble to its upper-case hex character, and the nibble adjustment for a letter digit
	localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
	localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;
	localparam logic [3:0] HEX_ALPHA_ADJ = 4'd9;

	// Mode register codes
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// One queued job: a ready result byte, or a byte still to be escaped
	typedef struct packed {
		logic [7:0] data;
		logic       expand;
		logic       str_end;
		logic       err;
	} upc_entry_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'h0, nib};
		return (nib > 4'd9) ? wide + HEX_ALPHA_OFS : wide + HEX_DIGIT_OFS;
	endfunction

endpackage

`default_nettype wire

/* rtl/upc_front.sv */
// Front end: accepts input words, classifies them and tracks decode escape state.
`default_nettype none

module upc_front
	import upc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       mode,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire logic       q_full,
	output logic            q_push,
	output upc_entry_t      q_wdata
);

	typedef enum logic [1:0] {DP_IDLE, DP_HIGH, DP_LOW} dphase_t;

	dphase_t    phase_q, phase_d;
	logic [3:0] high_nib_q, high_nib_d;
	logic [3:0] hv;
	logic       hv_ok;
	logic       has_res;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && has_res;

	// Hex digit value
	always_comb begin
		hv    = in_byte[3:0];
		hv_ok = 1'b0;
		if (in_byte inside {[CH_0:CH_9]}) begin
			hv_ok = 1'b1;
		end else if (in_byte inside {[CH_UA:CH_UF], [CH_LA:CH_LF]}) begin
			hv    = in_byte[3:0] + HEX_ALPHA_ADJ;
			hv_ok = 1'b1;
		end
	end

	// Classification and next escape state
	always_comb begin
		phase_d         = DP_IDLE;
		high_nib_d      = 4'h0;
		has_res         = 1'b1;
		q_wdata.data    = in_byte;
		q_wdata.expand  = 1'b0;
		q_wdata.str_end = in_last;
		q_wdata.err     = 1'b0;
		if (mode == MODE_ENCODE) begin
			if (in_byte inside {[CH_0:CH_9], [CH_UA:CH_UZ], [CH_LA:CH_LZ],
					CH_DASH, CH_USCORE, CH_DOT, CH_TILDE}) begin
				q_wdata.data = in_byte;
			end else if (in_byte == CH_SPACE) begin
				q_wdata.data = CH_PLUS;
			end else begin
				q_wdata.expand = 1'b1;
			end
		end else begin
			case (phase_q)
				DP_HIGH, DP_LOW: begin
					if (!hv_ok) begin
						q_wdata.data = 8'h00;
						q_wdata.err  = 1'b1;
					end else if (phase_q == DP_HIGH) begin
						if (in_last) begin
							q_wdata.data = 8'h00;
							q_wdata.err  = 1'b1;
						end else begin
							has_res    = 1'b0;
							phase_d    = DP_LOW;
							high_nib_d = hv;
						end
					end else begin
						q_wdata.data = {high_nib_q, hv};
					end
				end
				default: begin
					if (in_byte == CH_PERCENT) begin
						if (in_last) begin
							q_wdata.data = 8'h00;
							q_wdata.err  = 1'b1;
						end else begin
							has_res = 1'b0;
							phase_d = DP_HIGH;
						end
					end else if (in_byte == CH_PLUS) begin
						q_wdata.data = CH_SPACE;
					end
				end
			endcase
		end
	end

	// Escape state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= DP_IDLE;
			high_nib_q <= 4'h0;
		end else if (accept) begin
			phase_q    <= phase_d;
			high_nib_q <= high_nib_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/upc_queue.sv */
// Small job queue between the front end and the output expander.
`default_nettype none

module upc_queue
	import upc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire upc_entry_t  wdata,
	input  wire logic        pop,
	output upc_entry_t       rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	upc_entry_t     mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/upc_back.sv */
// Back end: expands escape jobs into three words and drives the output register.
`default_nettype none

module upc_back
	import upc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire upc_entry_t  q_rdata,
	input  wire logic        q_empty,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             string_end,
	output logic             bad_escape
);

	typedef enum logic [1:0] {PH_PCT, PH_HI, PH_LO} xphase_t;

	xphase_t    phase_q, phase_d;
	logic       load, take, part_last;
	logic [7:0] word;

	assign load = !out_valid || out_ready;
	assign take = load && !q_empty;

	// Pick the word for the current part of the job
	always_comb begin
		word      = q_rdata.data;
		part_last = 1'b1;
		phase_d   = PH_PCT;
		if (q_rdata.expand) begin
			case (phase_q)
				PH_PCT: begin
					word      = CH_PERCENT;
					part_last = 1'b0;
					phase_d   = PH_HI;
				end
				PH_HI: begin
					word      = hex_char(q_rdata.data[7:4]);
					part_last = 1'b0;
					phase_d   = PH_LO;
				end
				default: begin
					word = hex_char(q_rdata.data[3:0]);
				end
			endcase
		end
	end

	assign q_pop = take && part_last;

	// Expansion state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PCT;
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= !q_empty;
			if (take) begin
				phase_q    <= phase_d;
				out_byte   <= word;
				run_last   <= part_last;
				string_end <= q_rdata.str_end;
				bad_escape <= q_rdata.err;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/url_percent_codec.sv */
// Streaming URL percent encoder/decoder top level.
// A result word passes through the job queue and then the output register.
// Throughput: one input word per cycle while the QDEPTH-entry job queue has room; the
// output moves one word per cycle when out_ready allows: three per escaped byte in
// encode mode, none per non-final '%' or high digit in decode mode, else one.
// Reset clears the mode to encode, the decode escape state, the queue and out_valid.
`default_nettype none

module url_percent_codec
	import upc_pkg::*;
#(
	parameter int QDEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            string_end,
	output logic            bad_escape
);

	logic       mode_q;
	logic       q_push, q_pop, q_full, q_empty;
	upc_entry_t q_wdata, q_rdata;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCODE;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	upc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	upc_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	upc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_rdata    (q_rdata),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end),
		.bad_escape (bad_escape)
	);

`ifndef ASSERT_OFF
	// Queue cannot be full and empty at once
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue reports full and empty");

	// Error words carry a zero byte and close their run
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_escape |-> out_byte == 8'h00 && run_last)
		else $error("malformed error word");

	// Multi-word runs only come from escape expansion, never errors
	a_run_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !bad_escape)
		else $error("error word inside a run");

	// A pop only happens on a non-empty queue
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
